// File: design/bss_pkg.sv
// ----------------------------------------------------------------------------
// bss_pkg: shared definitions of the block selection sorter
// Value width, default block length and the control word that the top level
// broadcasts to every cell of the sorting chain.
// ----------------------------------------------------------------------------
package bss_pkg;

  localparam int BSS_VAL_W     = 8;
  localparam int BSS_BLOCK_LEN = 16;

  typedef logic [BSS_VAL_W-1:0] bss_val_t;

  // Broadcast control for the chain: insert a new value, or shift one place
  // toward cell zero.
  typedef struct packed {
    logic     insert;
    logic     shift;
    bss_val_t sample;
  } bss_ctl_t;

endpackage

// File: design/bss_ifs.sv
// ----------------------------------------------------------------------------
// bss_ifs: channel interfaces of the block selection sorter
// A valid/ready channel for incoming samples and one for sorted results.
// ----------------------------------------------------------------------------
interface bss_in_if;
  logic                        valid;
  logic                        ready;
  logic [bss_pkg::BSS_VAL_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface bss_out_if;
  logic                        valid;
  logic                        ready;
  logic [bss_pkg::BSS_VAL_W-1:0] sorted_value;
  logic                        block_end;

  modport source (output valid, output sorted_value, output block_end, input ready);
  modport sink   (input valid, input sorted_value, input block_end, output ready);
endinterface

// File: design/block_selection_sorter.sv
// ----------------------------------------------------------------------------
// block_selection_sorter: sorts blocks of unsigned 8-bit values
// Collects BLOCK_LEN samples and returns them in ascending order.
// ----------------------------------------------------------------------------
// The block takes BLOCK_LEN samples, one per transfer, and keeps them in a
// chain of BLOCK_LEN cells that stays sorted at all times: every cell compares
// the incoming sample against its own value in parallel, and the cells above
// the insertion point move one place up, all in one update when a sample is
// taken. When the last sample of a block has been taken, the chain drains
// toward cell zero, one value per result transfer, smallest first; the final
// (largest) value carries block_end. Equal values appear as many times as
// they were sent. While the block drains, the input is not ready, so filling
// and draining of a block never overlap. The output comes straight from the
// register of cell zero. Reset discards a partial block.
module block_selection_sorter #(
  parameter int BLOCK_LEN = bss_pkg::BSS_BLOCK_LEN
) (
  input  logic      clk,
  input  logic      rst,
  bss_in_if.sink    feed,
  bss_out_if.source result
);
  import bss_pkg::*;

  localparam int CNT_W = $clog2(BLOCK_LEN + 1);

  // In fill mode count is the number of samples held; in drain mode it is
  // the number of results still to send.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             draining;
  logic             draining_next;

  logic             in_xfer;
  logic             out_xfer;
  bss_ctl_t         ctl;

  logic     [BLOCK_LEN-1:0] keep;
  logic     [BLOCK_LEN-1:0] occupied;
  bss_val_t                 cell_value [BLOCK_LEN];

  assign feed.ready = !draining;
  assign in_xfer    = feed.valid && feed.ready;
  assign out_xfer   = result.valid && result.ready;

  assign ctl.insert = in_xfer;
  assign ctl.shift  = out_xfer;
  assign ctl.sample = feed.sample;

  always_comb begin
    count_next    = count;
    draining_next = draining;
    if (in_xfer) begin
      if (count == CNT_W'(BLOCK_LEN - 1)) begin
        draining_next = 1'b1;
        count_next    = CNT_W'(BLOCK_LEN);
      end else begin
        count_next = count + CNT_W'(1);
      end
    end else if (out_xfer) begin
      count_next = count - CNT_W'(1);
      if (count == CNT_W'(1)) begin
        draining_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      draining <= 1'b0;
    end else begin
      count    <= count_next;
      draining <= draining_next;
    end
  end

  // The chain itself: cell zero holds the smallest value.
  for (genvar i = 0; i < BLOCK_LEN; i++) begin : g_cell
    assign occupied[i] = (count > CNT_W'(i));

    if (i == 0) begin : g_head
      bss_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occupied   (occupied[i]),
        .prev_keep  (1'b1),
        .prev_value ('0),
        .next_value ((BLOCK_LEN > 1) ? cell_value[(BLOCK_LEN > 1) ? 1 : 0] : '0),
        .keep       (keep[i]),
        .value      (cell_value[i])
      );
    end else if (i == BLOCK_LEN - 1) begin : g_tail
      bss_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occupied   (occupied[i]),
        .prev_keep  (keep[i-1]),
        .prev_value (cell_value[i-1]),
        .next_value ('0),
        .keep       (keep[i]),
        .value      (cell_value[i])
      );
    end else begin : g_mid
      bss_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occupied   (occupied[i]),
        .prev_keep  (keep[i-1]),
        .prev_value (cell_value[i-1]),
        .next_value (cell_value[i+1]),
        .keep       (keep[i]),
        .value      (cell_value[i])
      );
    end
  end

  assign result.valid        = draining;
  assign result.sorted_value = cell_value[0];
  assign result.block_end    = (count == CNT_W'(1));

endmodule

// File: design/bss_cell.sv
// ----------------------------------------------------------------------------
// bss_cell: one slot of the insertion chain
// Holds one value. On insert it keeps its value, takes the new sample, or
// takes its left neighbor's value; on shift it takes its right neighbor's.
// ----------------------------------------------------------------------------
module bss_cell (
  input  logic                          clk,
  input  bss_pkg::bss_ctl_t             ctl,
  input  logic                          occupied,
  input  logic                          prev_keep,
  input  logic [bss_pkg::BSS_VAL_W-1:0] prev_value,
  input  logic [bss_pkg::BSS_VAL_W-1:0] next_value,
  output logic                          keep,
  output logic [bss_pkg::BSS_VAL_W-1:0] value
);
  import bss_pkg::*;

  bss_val_t value_next;

  // A cell keeps its value when it already holds something not above the
  // new sample; empty cells behave as if they held infinity.
  assign keep = occupied && (value <= ctl.sample);

  always_comb begin
    value_next = value;
    if (ctl.shift) begin
      value_next = next_value;
    end else if (ctl.insert && !keep) begin
      value_next = prev_keep ? ctl.sample : prev_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// File: dv/bss_sort_checker.sv
// ----------------------------------------------------------------------------
// bss_sort_checker: scoreboard of the block selection sorter
// Watches both channels, sorts every completed block of samples on its own,
// and compares each result transfer against the oldest sorted value due.
// ----------------------------------------------------------------------------
module bss_sort_checker #(
  parameter int BLOCK_LEN = bss_pkg::BSS_BLOCK_LEN
) (
  input  logic clk,
  input  logic rst,
  bss_in_if    feed,
  bss_out_if   result,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import bss_pkg::*;

  typedef struct {
    bss_val_t value;
    logic     last;
  } sorted_entry_t;

  sorted_entry_t sorted_due[$];
  bss_val_t      held[BLOCK_LEN];
  int            held_count = 0;
  int            errs = 0;
  int            due_count = 0;

  assign fail_count = errs;
  assign pending    = due_count;

  // Keeps the samples of the current block; the sample that fills the block
  // releases the whole block in ascending order, the largest one flagged.
  task automatic collect_sample(input bss_val_t v);
    bss_val_t      ordered[BLOCK_LEN];
    bss_val_t      tmp;
    sorted_entry_t entry;
    int            j;
    held[held_count] = v;
    held_count++;
    if (held_count == BLOCK_LEN) begin
      ordered = held;
      for (int i = 1; i < BLOCK_LEN; i++) begin
        j = i;
        while (j > 0 && ordered[j-1] > ordered[j]) begin
          tmp          = ordered[j];
          ordered[j]   = ordered[j-1];
          ordered[j-1] = tmp;
          j--;
        end
      end
      for (int i = 0; i < BLOCK_LEN; i++) begin
        entry.value = ordered[i];
        entry.last  = (i == BLOCK_LEN - 1);
        sorted_due.push_back(entry);
      end
      held_count = 0;
    end
  endtask

  task automatic check_result(input bss_val_t v, input logic last);
    sorted_entry_t want;
    if (sorted_due.size() == 0) begin
      $error("unexpected result: sorted_value=%0d block_end=%0b", v, last);
      errs++;
    end else begin
      want = sorted_due.pop_front();
      if (v !== want.value) begin
        $error("sorted_value: expected %0d, actual %0d", want.value, v);
        errs++;
      end
      if (last !== want.last) begin
        $error("block_end: expected %0b, actual %0b", want.last, last);
        errs++;
      end
    end
  endtask

  // Results are checked before the sample of the same edge is taken in; the
  // block never accepts a sample while it still drains, so the order is safe.
  always @(posedge clk) begin
    if (rst) begin
      sorted_due.delete();
      held_count = 0;
    end else begin
      if (result.valid && result.ready) begin
        check_result(result.sorted_value, result.block_end);
      end
      if (feed.valid && feed.ready) begin
        collect_sample(feed.sample);
      end
    end
    due_count <= sorted_due.size();
  end

endmodule

// File: dv/tb_block_selection_sorter.sv
// ----------------------------------------------------------------------------
// tb_block_selection_sorter: testbench of the block selection sorter
// Sends one directed block of edge values and then blocks of random samples
// in several shapes, with random gaps on the sending and receiving sides.
// A separate scoreboard predicts every sorted block and checks the results.
// ----------------------------------------------------------------------------
module tb_block_selection_sorter;
  timeunit 1ns;
  timeprecision 1ps;

  import bss_pkg::*;

  localparam int BLOCK_LEN     = BSS_BLOCK_LEN;
  localparam int RANDOM_BLOCKS = 17;
  localparam int IDLE_LIMIT    = 1000;

  // Shapes of a random block. Sorted and reverse-sorted input exercise the
  // two ends of the insertion chain, while flat and few-valued blocks stress
  // the handling of equal values.
  typedef enum int {
    PAT_UNIFORM,
    PAT_FLAT,
    PAT_RISING,
    PAT_FALLING,
    PAT_FEW,
    PAT_EXTREME
  } block_shape_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic steady = 1'b0;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;

  bss_in_if  feed();
  bss_out_if result();

  block_selection_sorter #(
    .BLOCK_LEN(BLOCK_LEN)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .feed  (feed),
    .result(result)
  );

  bss_sort_checker #(
    .BLOCK_LEN(BLOCK_LEN)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .feed      (feed),
    .result    (result),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap lengths: about half of them zero, most of the rest short, and
  // now and then a long stretch that lets the other side run far ahead.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // One sample transfer. The gap, if any, lowers valid first; otherwise valid
  // simply stays high so back-to-back transfers get a single assignment per
  // edge. The task returns at the edge where the transfer happened.
  task automatic send_sample(input bss_val_t v);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      feed.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    feed.valid  <= 1'b1;
    feed.sample <= v;
    do @(posedge clk); while (!feed.ready);
  endtask

  // Holds the sender back until the block has handed out every sorted value
  // that the scoreboard still waits for. The first edge lets the count catch
  // up with a block that was completed at the edge just passed.
  task automatic hold_until_drained();
    feed.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_random_block(input block_shape_t shape);
    bss_val_t pick_a;
    bss_val_t pick_b;
    bss_val_t v;
    int       band;
    band   = 256 / BLOCK_LEN;
    pick_a = bss_val_t'($urandom_range(0, 255));
    pick_b = bss_val_t'($urandom_range(0, 255));
    for (int i = 0; i < BLOCK_LEN; i++) begin
      case (shape)
        PAT_FLAT: begin
          v = pick_a;
        end
        PAT_RISING: begin
          v = bss_val_t'(i * band + $urandom_range(0, band - 1));
        end
        PAT_FALLING: begin
          v = bss_val_t'(255 - i * band - $urandom_range(0, band - 1));
        end
        PAT_FEW: begin
          v = $urandom_range(0, 1) ? pick_a : pick_b;
        end
        PAT_EXTREME: begin
          case ($urandom_range(0, 3))
            0: v = 8'd0;
            1: v = 8'd255;
            2: v = 8'd1;
            default: v = 8'd254;
          endcase
        end
        default: begin
          v = bss_val_t'($urandom_range(0, 255));
        end
      endcase
      send_sample(v);
    end
  endtask

  // The receiving side alternates bursts of ready with stalls of random
  // length, except in steady stretches where it keeps ready high.
  initial begin : result_ready_driver
    int len;
    result.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (steady) begin
        result.ready <= 1'b1;
        @(posedge clk);
      end else begin
        len = $urandom_range(1, 12);
        result.ready <= 1'b1;
        repeat (len) @(posedge clk);
        len = pick_gap();
        if (len > 0) begin
          result.ready <= 1'b0;
          repeat (len) @(posedge clk);
        end
      end
    end
  end

  // The watchdog counts edges at which neither channel completes a transfer.
  // A hung handshake, or a block that never drains, ends the run here.
  always @(posedge clk) begin
    if (rst || (feed.valid && feed.ready) || (result.valid && result.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    bss_val_t edge_block[BLOCK_LEN];
    feed.valid  = 1'b0;
    feed.sample = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed block: both extremes, each of them repeated, the values one
    // away from them, alternating bit patterns and a few mid-range values.
    // The samples arrive in no particular order so that every insertion
    // point of the chain sees use.
    for (int i = 0; i < BLOCK_LEN; i++) begin
      edge_block[i] = bss_val_t'($urandom_range(0, 255));
    end
    edge_block[0]  = 8'd255;
    edge_block[1]  = 8'd0;
    edge_block[2]  = 8'd128;
    edge_block[3]  = 8'd127;
    edge_block[4]  = 8'd1;
    edge_block[5]  = 8'd254;
    edge_block[6]  = 8'd0;
    edge_block[7]  = 8'd255;
    edge_block[8]  = 8'h55;
    edge_block[9]  = 8'hAA;
    edge_block[10] = 8'h0F;
    edge_block[11] = 8'hF0;
    edge_block[12] = 8'h55;
    edge_block[13] = 8'd7;
    for (int i = 0; i < BLOCK_LEN; i++) begin
      send_sample(edge_block[i]);
    end

    // The sender waits here until the directed block has drained, so the
    // next block starts into an empty, idle sorter.
    hold_until_drained();

    // Random part: one block in four runs without gaps on either side, and
    // now and then the sender waits for the sorter to drain completely.
    for (int b = 0; b < RANDOM_BLOCKS; b++) begin
      steady <= ($urandom_range(0, 3) == 0);
      send_random_block(block_shape_t'($urandom_range(PAT_UNIFORM, PAT_EXTREME)));
      if ($urandom_range(0, 4) == 0) begin
        hold_until_drained();
      end
    end

    // All samples are in. Wait for the last results, then give the block a
    // little time to show any stray transfer before the verdict.
    steady <= 1'b0;
    hold_until_drained();
    repeat (BLOCK_LEN + 4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
